### hw/rtl/tmm_pkg.sv
// Shared types, codes and arithmetic constants of the temperature monitor.
`default_nettype none

package tmm_pkg;

   // Command line store: default depth and the command word that is matched
   localparam int LINE_DEPTH_DEF = 15;
   localparam int MATCH_LEN      = 5;
   localparam int MATCH_IDX_W    = $clog2(MATCH_LEN);
   localparam logic [7:0] MATCH_WORD [MATCH_LEN] = '{8'h52, 8'h45, 8'h53, 8'h45, 8'h54};
   localparam logic [7:0] CHAR_CR = 8'h0d;
   localparam logic [7:0] CHAR_LF = 8'h0a;

   // Configuration register indexes
   localparam int CSR_ADDR_W = 4;
   localparam logic [CSR_ADDR_W-1:0] CSR_CHANGE_BAND = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_WARN_LIMIT  = CSR_ADDR_W'(1);
   localparam logic [15:0] CHANGE_BAND_RST = 16'd10;
   localparam logic [15:0] WARN_LIMIT_RST  = 16'd4000;

   // Result kinds
   localparam logic [1:0] KIND_REPORT     = 2'd0;
   localparam logic [1:0] KIND_RESET_DONE = 2'd1;
   localparam logic [1:0] KIND_UNKNOWN    = 2'd2;

   // Tracker reset values
   localparam logic [15:0] MIN_RST  = 16'd10000;
   localparam logic [15:0] MAX_RST  = 16'd0;
   localparam logic [16:0] LAST_RST = -17'sd100;

   // Conversion constants for the shared multiplier
   // C = floor(code * 33000 / 1023): divide by 1023 as (x * ceil(2^35/1023)) >> 35
   // F = floor(C * 9 / 5) + 3200:     divide by 5    as (x * ceil(2^21/5))    >> 21
   localparam int MUL_A_W = 26;
   localparam int MUL_B_W = 26;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam logic [15:0] SCALE_NUM  = 16'd33000;
   localparam logic [25:0] RECIP_1023 = 26'd33587233;
   localparam int          SHIFT_1023 = 35;
   localparam logic [3:0]  TIMES_NINE = 4'd9;
   localparam logic [18:0] RECIP_5    = 19'd419431;
   localparam int          SHIFT_5    = 21;
   localparam logic [15:0] F_OFFSET   = 16'd3200;

   typedef struct packed {
      logic       cmd;
      logic [9:0] adc_code;
      logic [7:0] rx_char;
   } tmm_req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] celsius_centi;
      logic [15:0] fahrenheit_centi;
      logic [15:0] lowest_centi;
      logic [15:0] highest_centi;
      logic        over_limit;
   } tmm_rsp_type;

endpackage

`default_nettype wire

### hw/rtl/temperature_monitor_min_max.sv
// Temperature monitor: ADC scaling, min/max tracking, change reports and command line.
//
// Usage:
//  - req channel: one beat is either an ADC sample (cmd = 0, adc_code) or one
//    received command character (cmd = 1, rx_char).
//  - rsp channel: zero or one result beat per request beat: a temperature
//    report, a min/max reset confirmation, or an unknown command notice.
//  - csr port: index 0 = change_band, index 1 = warn_limit; write while idle.
//  - A sample holds the block while it steps through the shared 26x26
//    multiplier for scale, /1023, x9 and /5, then a compare state and, if it
//    reports, an output state that registers the result.
//  - A character passes through a character state, then the output state when it ends a line.
//  - req_stall is high while the sequencer works on a beat; the next beat is
//    taken as soon as it is back in idle, even if a result still waits in the
//    output register.
//  - When the receiver stalls, a finished result waits in the sequencer until
//    the output register is free; nothing is dropped.
//  - Reset (synchronous): configuration registers to defaults, min/max
//    restored, line emptied, no result pending.
`default_nettype none

module temperature_monitor_min_max #(
   parameter int LINE_DEPTH = tmm_pkg::LINE_DEPTH_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire tmm_pkg::tmm_req_type         req_data,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output tmm_pkg::tmm_rsp_type              rsp_data,
   input  wire                               csr_we,
   input  wire [tmm_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  wire [15:0]                        csr_wdata
);

   import tmm_pkg::*;

   localparam int LEN_W = $clog2(LINE_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_DIV_C,
      ST_TIMES9,
      ST_DIV_F,
      ST_EVAL,
      ST_CHAR,
      ST_OUT
   } state_type;

   state_type         state_ff, state_in;
   tmm_req_type       item_ff;
   logic [MUL_P_W-1:0] prod_ff, prod_in;
   logic [15:0]       c_ff, c_in;
   logic [15:0]       f_ff, f_in;
   logic [1:0]        kind_ff, kind_in;
   logic              over_ff, over_in;
   logic [15:0]       band_ff, band_in;
   logic [15:0]       warn_ff, warn_in;
   logic [15:0]       min_ff, min_in;
   logic [15:0]       max_ff, max_in;
   logic [16:0]       last_ff, last_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              rsp_valid_ff, rsp_valid_in;
   tmm_rsp_type       rsp_data_ff, rsp_data_in;
   // Only the first entries of a line can ever match, so only they are kept
   logic [7:0]        line_ff [MATCH_LEN];
   logic              line_we;

   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [MUL_P_W-1:0] mul_p;
   logic [17:0]        diff;
   logic [16:0]        mag;
   logic               word_match;
   logic               is_eol;
   logic               req_take;
   logic               out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Shared multiplier, operands chosen by the sequencer
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SCALE: begin
            mul_a = MUL_A_W'(item_ff.adc_code);
            mul_b = MUL_B_W'(SCALE_NUM);
         end
         ST_DIV_C: begin
            mul_a = prod_ff[MUL_A_W-1:0];
            mul_b = RECIP_1023;
         end
         ST_TIMES9: begin
            mul_a = MUL_A_W'(c_ff);
            mul_b = MUL_B_W'(TIMES_NINE);
         end
         ST_DIV_F: begin
            mul_a = prod_ff[MUL_A_W-1:0];
            mul_b = MUL_B_W'(RECIP_5);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

   // Distance from the last reported value
   assign diff = {2'b00, c_ff} - {last_ff[16], last_ff};
   assign mag  = diff[17] ? 17'(-diff) : diff[16:0];

   // Line compare against the command word
   always_comb begin
      word_match = (len_ff == LEN_W'(MATCH_LEN));
      for (int i = 0; i < MATCH_LEN; i++) begin
         if (line_ff[i] != MATCH_WORD[i]) begin
            word_match = 1'b0;
         end
      end
   end

   assign is_eol = (item_ff.rx_char == CHAR_CR) || (item_ff.rx_char == CHAR_LF);

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      prod_in      = prod_ff;
      c_in         = c_ff;
      f_in         = f_ff;
      kind_in      = kind_ff;
      over_in      = over_ff;
      band_in      = band_ff;
      warn_in      = warn_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      last_in      = last_ff;
      len_in       = len_ff;
      line_we      = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      if (csr_we) begin
         case (csr_addr)
            CSR_CHANGE_BAND: band_in = csr_wdata;
            CSR_WARN_LIMIT:  warn_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = req_data.cmd ? ST_CHAR : ST_SCALE;
            end
         end
         ST_SCALE: begin
            prod_in  = mul_p;
            state_in = ST_DIV_C;
         end
         ST_DIV_C: begin
            c_in     = mul_p[SHIFT_1023 +: 16];
            state_in = ST_TIMES9;
         end
         ST_TIMES9: begin
            prod_in  = mul_p;
            state_in = ST_DIV_F;
         end
         ST_DIV_F: begin
            f_in     = mul_p[SHIFT_5 +: 16] + F_OFFSET;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (c_ff < min_ff) min_in = c_ff;
            if (c_ff > max_ff) max_in = c_ff;
            if (mag > {1'b0, band_ff}) begin
               last_in  = {1'b0, c_ff};
               kind_in  = KIND_REPORT;
               over_in  = (c_ff > warn_ff);
               state_in = ST_OUT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_CHAR: begin
            if (is_eol) begin
               if (word_match) begin
                  min_in  = MIN_RST;
                  max_in  = MAX_RST;
                  kind_in = KIND_RESET_DONE;
               end else begin
                  kind_in = KIND_UNKNOWN;
               end
               c_in     = '0;
               f_in     = '0;
               over_in  = 1'b0;
               len_in   = '0;
               state_in = ST_OUT;
            end else begin
               if (len_ff < LEN_W'(LINE_DEPTH)) begin
                  line_we = (len_ff < LEN_W'(MATCH_LEN));
                  len_in  = len_ff + LEN_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.kind             = kind_ff;
               rsp_data_in.celsius_centi    = c_ff;
               rsp_data_in.fahrenheit_centi = f_ff;
               rsp_data_in.lowest_centi     = min_ff;
               rsp_data_in.highest_centi    = max_ff;
               rsp_data_in.over_limit       = over_ff;
               state_in                     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State, registered outputs and datapath registers
   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      c_ff        <= c_in;
      f_ff        <= f_in;
      kind_ff     <= kind_in;
      over_ff     <= over_in;
      rsp_data_ff <= rsp_data_in;
      if (req_take) begin
         item_ff <= req_data;
      end
      if (line_we) begin
         line_ff[len_ff[MATCH_IDX_W-1:0]] <= item_ff.rx_char;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         band_ff      <= CHANGE_BAND_RST;
         warn_ff      <= WARN_LIMIT_RST;
         min_ff       <= MIN_RST;
         max_ff       <= MAX_RST;
         last_ff      <= LAST_RST;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         band_ff      <= band_in;
         warn_ff      <= warn_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         last_ff      <= last_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A new result beat only comes from the output state
   assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT)))
      else $error("result beat appeared without output state");

   // Reset confirmations carry restored trackers
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.kind == KIND_RESET_DONE) |->
         (rsp_data_ff.lowest_centi == MIN_RST) && (rsp_data_ff.highest_centi == MAX_RST)))
      else $error("reset confirmation with stale min/max");

   // Command results carry no temperature
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.kind != KIND_REPORT) |->
         (rsp_data_ff.celsius_centi == 16'd0) && !rsp_data_ff.over_limit))
      else $error("command result with temperature data");

   // Line count stays within the store depth
   assert property (@(posedge clock) disable iff (reset)
      (len_ff <= LEN_W'(LINE_DEPTH)))
      else $error("line length beyond depth");

endmodule

`default_nettype wire
